>>> rtl/member_slot_table_core_defines.svh
// Assertion macros shared by the slot table RTL.
// MST_ASSERT_NOW checks the consequent in the same cycle as the antecedent,
// MST_ASSERT_NEXT checks it in the cycle after.
`ifndef MEMBER_SLOT_TABLE_CORE_DEFINES_SVH
`define MEMBER_SLOT_TABLE_CORE_DEFINES_SVH

`ifndef SYNTH
`define MST_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
`define MST_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MST_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg)
`define MST_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

>>> rtl/mst_pkg.sv
`timescale 1ns / 1ps
package mst_pkg;

    localparam int SLOTS     = 64;
    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W     = ($clog2(SLOTS + 1) > 7) ? $clog2(SLOTS + 1) : 7;
    localparam int SR_W      = 7;
    localparam int IDX_EXT_W = (SLOT_W > SR_W) ? SLOT_W : SR_W;
    localparam int ID_W      = 31;
    localparam int FOUND_W   = 32;
    localparam int FUNC_W    = 3;

    localparam logic [FOUND_W-1:0] NONE_ID = {FOUND_W{1'b1}};

    localparam logic [FUNC_W-1:0] F_INSERT      = 3'd0;
    localparam logic [FUNC_W-1:0] F_REMOVE_ID   = 3'd1;
    localparam logic [FUNC_W-1:0] F_REMOVE_SLOT = 3'd2;
    localparam logic [FUNC_W-1:0] F_CLEAR       = 3'd3;
    localparam logic [FUNC_W-1:0] F_TRIM        = 3'd4;
    localparam logic [FUNC_W-1:0] F_CONTAINS    = 3'd5;
    localparam logic [FUNC_W-1:0] F_NTH         = 3'd6;

    localparam int APB_AW = 3;
    localparam logic REG_DESIRED_COUNT = 1'b0;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        logic [ID_W-1:0]   wdata;
        logic [SLOT_W-1:0] raddr;
    } t_ram_req;

endpackage

>>> rtl/mst_if.sv
`timescale 1ns / 1ps
interface mst_req_if;
    logic                       valid;
    logic                       ready;
    logic [mst_pkg::FUNC_W-1:0] func;
    logic [mst_pkg::ID_W-1:0]   member_id;
    logic [mst_pkg::SR_W-1:0]   slot_or_rank;

    modport source (output valid, func, member_id, slot_or_rank, input ready);
    modport sink   (input valid, func, member_id, slot_or_rank, output ready);
endinterface

interface mst_rsp_if;
    logic                              valid;
    logic                              ready;
    logic                              ok;
    logic signed [mst_pkg::FOUND_W-1:0] found_id;
    logic [6:0]                        member_count;

    modport source (output valid, ok, found_id, member_count, input ready);
    modport sink   (input valid, ok, found_id, member_count, output ready);
endinterface

>>> rtl/mst_ram.sv
`timescale 1ns / 1ps
module mst_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 31
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/mst_apb.sv
`timescale 1ns / 1ps
module mst_apb (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mst_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output logic [6:0]                 o_desired_count
);

    logic [6:0] r_desired;
    logic       reg_sel;

    // register index is the word address
    assign reg_sel = (paddr[2] == mst_pkg::REG_DESIRED_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_desired <= '0;
        end else if (psel && penable && pwrite && reg_sel) begin
            r_desired <= pwdata[6:0];
        end
    end

    assign pready          = 1'b1;
    assign prdata          = reg_sel ? {25'd0, r_desired} : 32'd0;
    assign o_desired_count = r_desired;

endmodule

>>> rtl/mst_engine.sv
`timescale 1ns / 1ps
`include "member_slot_table_core_defines.svh"
module mst_engine (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    mst_req_if.sink                        i_req,
    mst_rsp_if.source                      o_rsp,
    input  logic [6:0]                     i_desired_count,
    output mst_pkg::t_ram_req              o_ram,
    input  logic [mst_pkg::ID_W-1:0]       i_ram_rdata
);

    localparam int SLOTS   = mst_pkg::SLOTS;
    localparam int SLOT_W  = mst_pkg::SLOT_W;
    localparam int CNT_W   = mst_pkg::CNT_W;
    localparam int ID_W    = mst_pkg::ID_W;
    localparam int FOUND_W = mst_pkg::FOUND_W;
    localparam int XW      = mst_pkg::IDX_EXT_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    // control state
    logic [1:0]              r_state, n_state;
    logic [SLOTS-1:0]        r_used, n_used;
    logic [CNT_W-1:0]        r_count, n_count;
    logic                    r_s1_run, n_s1_run;
    logic                    r_p_go, n_p_go;
    logic                    r_out_vld, n_out_vld;

    // payload
    logic [mst_pkg::FUNC_W-1:0] r_func, n_func;
    logic [ID_W-1:0]         r_id, n_id;
    logic [mst_pkg::SR_W-1:0] r_rank, n_rank;
    logic                    r_trim_ok, n_trim_ok;
    logic [SLOT_W-1:0]       r_idx, n_idx;
    logic [SLOT_W-1:0]       r_p_idx, n_p_idx;
    logic                    r_p_used, n_p_used;
    logic                    r_p_last, n_p_last;
    logic [CNT_W-1:0]        r_seen, n_seen;
    logic                    r_hold_ok, n_hold_ok;
    logic [FOUND_W-1:0]      r_hold_found, n_hold_found;
    logic [6:0]              r_hold_count, n_hold_count;
    logic                    r_out_ok, n_out_ok;
    logic [FOUND_W-1:0]      r_out_found, n_out_found;
    logic [6:0]              r_out_count, n_out_count;

    logic                    fin;
    logic                    f_ok;
    logic [FOUND_W-1:0]      f_found;
    logic                    out_free;
    logic                    slot_hit;
    logic [CNT_W-1:0]        desired_ext;
    logic [XW-1:0]           sr_ext;
    logic                    sr_in_range;
    logic [SLOT_W-1:0]       sr_idx;
    logic                    acc;

    assign i_req.ready = (r_state == ST_IDLE);
    assign acc         = i_req.valid && (r_state == ST_IDLE);
    assign out_free    = !r_out_vld || o_rsp.ready;
    assign slot_hit    = r_p_used && (i_ram_rdata == r_id);
    assign desired_ext = CNT_W'(i_desired_count);
    assign sr_ext      = XW'(i_req.slot_or_rank);
    assign sr_in_range = {1'b0, sr_ext} < (XW + 1)'(SLOTS);
    assign sr_idx      = sr_ext[SLOT_W-1:0];

    always_comb begin
        n_state      = r_state;
        n_used       = r_used;
        n_count      = r_count;
        n_s1_run     = r_s1_run;
        n_p_go       = r_p_go;
        n_func       = r_func;
        n_id         = r_id;
        n_rank       = r_rank;
        n_trim_ok    = r_trim_ok;
        n_idx        = r_idx;
        n_p_idx      = r_p_idx;
        n_p_used     = r_p_used;
        n_p_last     = r_p_last;
        n_seen       = r_seen;
        n_hold_ok    = r_hold_ok;
        n_hold_found = r_hold_found;
        n_hold_count = r_hold_count;
        n_out_ok     = r_out_ok;
        n_out_found  = r_out_found;
        n_out_count  = r_out_count;
        n_out_vld    = r_out_vld && !o_rsp.ready;
        fin          = 1'b0;
        f_ok         = 1'b0;
        f_found      = mst_pkg::NONE_ID;
        o_ram.we     = 1'b0;
        o_ram.waddr  = r_p_idx;
        o_ram.wdata  = r_id;
        o_ram.raddr  = r_idx;

        case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    case (i_req.func)
                        mst_pkg::F_INSERT, mst_pkg::F_REMOVE_ID, mst_pkg::F_TRIM,
                        mst_pkg::F_CONTAINS, mst_pkg::F_NTH: begin
                            n_state   = ST_SCAN;
                            n_s1_run  = 1'b1;
                            n_p_go    = 1'b0;
                            n_idx     = '0;
                            n_seen    = '0;
                            n_func    = i_req.func;
                            n_id      = i_req.member_id;
                            n_rank    = i_req.slot_or_rank;
                            n_trim_ok = desired_ext < r_count;
                        end
                        mst_pkg::F_REMOVE_SLOT: begin
                            fin = 1'b1;
                            if (sr_in_range && r_used[sr_idx]) begin
                                n_used[sr_idx] = 1'b0;
                                n_count        = r_count - CNT_W'(1);
                                f_ok           = 1'b1;
                            end
                        end
                        mst_pkg::F_CLEAR: begin
                            fin     = 1'b1;
                            n_used  = '0;
                            n_count = '0;
                            f_ok    = 1'b1;
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // issue: read one slot per cycle
                if (r_s1_run) begin
                    n_p_go   = 1'b1;
                    n_p_idx  = r_idx;
                    n_p_used = r_used[r_idx];
                    n_p_last = (r_idx == SLOT_W'(SLOTS - 1));
                    n_idx    = r_idx + SLOT_W'(1);
                    if (r_idx == SLOT_W'(SLOTS - 1)) begin
                        n_s1_run = 1'b0;
                    end
                end else begin
                    n_p_go = 1'b0;
                end
                // evaluate: slot data is back from the memory
                if (r_p_go) begin
                    case (r_func)
                        mst_pkg::F_INSERT: begin
                            if (!r_p_used) begin
                                o_ram.we          = 1'b1;
                                n_used[r_p_idx]   = 1'b1;
                                n_count           = r_count + CNT_W'(1);
                                fin               = 1'b1;
                                f_ok              = 1'b1;
                            end
                        end
                        mst_pkg::F_REMOVE_ID: begin
                            if (slot_hit) begin
                                n_used[r_p_idx] = 1'b0;
                                n_count         = r_count - CNT_W'(1);
                                fin             = 1'b1;
                                f_ok            = 1'b1;
                            end
                        end
                        mst_pkg::F_CONTAINS: begin
                            if (slot_hit) begin
                                fin  = 1'b1;
                                f_ok = 1'b1;
                            end
                        end
                        mst_pkg::F_TRIM: begin
                            if (r_p_used && (desired_ext < r_count)) begin
                                n_used[r_p_idx] = 1'b0;
                                n_count         = r_count - CNT_W'(1);
                            end
                        end
                        mst_pkg::F_NTH: begin
                            if (r_p_used) begin
                                if (r_seen == CNT_W'(r_rank)) begin
                                    fin     = 1'b1;
                                    f_ok    = 1'b1;
                                    f_found = {1'b0, i_ram_rdata};
                                end else begin
                                    n_seen = r_seen + CNT_W'(1);
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (!fin && r_p_last) begin
                        fin  = 1'b1;
                        f_ok = (r_func == mst_pkg::F_TRIM) && r_trim_ok;
                    end
                end
                if (fin) begin
                    n_s1_run = 1'b0;
                    n_p_go   = 1'b0;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    n_out_vld   = 1'b1;
                    n_out_ok    = r_hold_ok;
                    n_out_found = r_hold_found;
                    n_out_count = r_hold_count;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // drop the result into the output register, or park it
        if (fin) begin
            if (out_free) begin
                n_out_vld   = 1'b1;
                n_out_ok    = f_ok;
                n_out_found = f_found;
                n_out_count = n_count[6:0];
                n_state     = ST_IDLE;
            end else begin
                n_hold_ok    = f_ok;
                n_hold_found = f_found;
                n_hold_count = n_count[6:0];
                n_state      = ST_HOLD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_used    <= '0;
            r_count   <= '0;
            r_s1_run  <= 1'b0;
            r_p_go    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_used    <= n_used;
            r_count   <= n_count;
            r_s1_run  <= n_s1_run;
            r_p_go    <= n_p_go;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func       <= n_func;
        r_id         <= n_id;
        r_rank       <= n_rank;
        r_trim_ok    <= n_trim_ok;
        r_idx        <= n_idx;
        r_p_idx      <= n_p_idx;
        r_p_used     <= n_p_used;
        r_p_last     <= n_p_last;
        r_seen       <= n_seen;
        r_hold_ok    <= n_hold_ok;
        r_hold_found <= n_hold_found;
        r_hold_count <= n_hold_count;
        r_out_ok     <= n_out_ok;
        r_out_found  <= n_out_found;
        r_out_count  <= n_out_count;
    end

    assign o_rsp.valid        = r_out_vld;
    assign o_rsp.ok           = r_out_ok;
    assign o_rsp.found_id     = r_out_found;
    assign o_rsp.member_count = r_out_count;

    `MST_ASSERT_NOW(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(SLOTS), "count above table size")
    `MST_ASSERT_NOW(a_insert_free, i_clk, i_rst_n, o_ram.we, !r_used[r_p_idx], "insert overwrites a used slot")
    `MST_ASSERT_NOW(a_hold_out, i_clk, i_rst_n, r_state == ST_HOLD, r_out_vld, "parked result with empty output")
    `MST_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, acc, (r_state != ST_IDLE) || r_out_vld, "accepted word left no trace")

endmodule

>>> rtl/member_slot_table_core.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake          Word
// i_req     in   valid/ready        func, member_id, slot_or_rank
// o_rsp     out  valid/ready        ok, found_id, member_count
// apb       in   psel/penable/pwrite desired_count at byte address 0
//
// Insert, remove by id, trim, contains and nth walk the id memory one slot per
// cycle through its single read port and answer at the end of the walk
// (earlier when a hit ends the walk early).
// Remove by slot, clear and unused codes skip the walk and go straight to the output register.
// Reset is synchronous and clears the occupancy bits and count at once; the id
// memory itself needs no clearing pass.
// One word is in work at a time; a finished result is parked while o_rsp stalls.
module member_slot_table_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    mst_req_if.sink                    i_req,
    mst_rsp_if.source                  o_rsp,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mst_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    logic [6:0]                 desired_count;
    mst_pkg::t_ram_req          ram_req;
    logic [mst_pkg::ID_W-1:0]   ram_rdata;

    // configuration register
    mst_apb u_apb (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_desired_count (desired_count)
    );

    // id store: one write and one registered read per cycle
    mst_ram #(
        .DEPTH (mst_pkg::SLOTS),
        .WIDTH (mst_pkg::ID_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    // scan sequencer, occupancy bits, count and result register
    mst_engine u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req           (i_req),
        .o_rsp           (o_rsp),
        .i_desired_count (desired_count),
        .o_ram           (ram_req),
        .i_ram_rdata     (ram_rdata)
    );

endmodule

>>> tb/sv/tb_member_slot_table_core.sv
`timescale 1ns / 1ps
module tb_member_slot_table_core;

    localparam int SLOTS   = mst_pkg::SLOTS;
    localparam int ID_W    = mst_pkg::ID_W;
    localparam int SR_W    = mst_pkg::SR_W;
    localparam int FUNC_W  = mst_pkg::FUNC_W;
    localparam int FOUND_W = mst_pkg::FOUND_W;
    localparam int APB_AW  = mst_pkg::APB_AW;

    // Unused function code: the block must answer it without touching the table.
    localparam logic [FUNC_W-1:0] F_UNUSED = 3'd7;

    // Generous bound on the whole run; the slowest legal run stays far below it.
    localparam int CYCLE_LIMIT = 1000000;

    // One result word as the block should return it.
    typedef struct {
        logic                 ok;
        logic [FOUND_W-1:0]   found_id;
        logic [6:0]           member_count;
    } t_member_answer;

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_AW-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    mst_req_if req_if ();
    mst_rsp_if rsp_if ();

    member_slot_table_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the slot table, the count and the trim target.
    logic [ID_W-1:0] roster_id [SLOTS];
    bit              roster_used [SLOTS];
    int              roster_count;
    logic [6:0]      roster_target;

    // Answers predicted for accepted words, oldest first.
    t_member_answer answer_q[$];

    int err_count;
    int cycle_count;
    bit no_idle;

    // Clock: 12 ns period.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog: end the run if the block hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    function automatic void roster_empty();
        for (int i = 0; i < SLOTS; i++) begin
            roster_used[i] = 1'b0;
            roster_id[i]   = '0;
        end
        roster_count = 0;
    endfunction

    // Free one slot; the count never drops below zero.
    function automatic void roster_drop(int slot);
        roster_used[slot] = 1'b0;
        if (roster_count > 0)
            roster_count--;
    endfunction

    // Apply one accepted word to the shadow table and return the answer it earns.
    function automatic t_member_answer roster_apply(logic [FUNC_W-1:0] f,
                                                    logic [ID_W-1:0] id,
                                                    logic [SR_W-1:0] sr);
        t_member_answer a;
        int seen;
        bit hit;
        a.ok       = 1'b0;
        a.found_id = mst_pkg::NONE_ID;
        seen       = 0;
        hit        = 1'b0;
        case (f)
            mst_pkg::F_INSERT: begin
                // Lowest free slot wins; a full table stays as it is.
                for (int i = 0; i < SLOTS; i++) begin
                    if (!hit && !roster_used[i]) begin
                        roster_used[i] = 1'b1;
                        roster_id[i]   = id;
                        roster_count++;
                        hit = 1'b1;
                    end
                end
                a.ok = hit;
            end
            mst_pkg::F_REMOVE_ID: begin
                // Only the first matching slot goes.
                for (int i = 0; i < SLOTS; i++) begin
                    if (!hit && roster_used[i] && roster_id[i] == id) begin
                        roster_drop(i);
                        hit = 1'b1;
                    end
                end
                a.ok = hit;
            end
            mst_pkg::F_REMOVE_SLOT: begin
                // Out of range or already empty: fail, count untouched.
                if (int'(sr) < SLOTS && roster_used[int'(sr)]) begin
                    roster_drop(int'(sr));
                    a.ok = 1'b1;
                end
            end
            mst_pkg::F_CLEAR: begin
                roster_empty();
                a.ok = 1'b1;
            end
            mst_pkg::F_TRIM: begin
                // Drop the lowest occupied slots until the target is met.
                if (int'(roster_target) < roster_count && roster_count > 0) begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (int'(roster_target) >= roster_count)
                            break;
                        if (roster_used[i])
                            roster_drop(i);
                    end
                    a.ok = 1'b1;
                end
            end
            mst_pkg::F_CONTAINS: begin
                for (int i = 0; i < SLOTS; i++)
                    if (roster_used[i] && roster_id[i] == id)
                        hit = 1'b1;
                a.ok = hit;
            end
            mst_pkg::F_NTH: begin
                // Rank counts occupied slots only, from zero.
                for (int i = 0; i < SLOTS; i++) begin
                    if (!hit && roster_used[i]) begin
                        if (seen == int'(sr)) begin
                            a.found_id = {1'b0, roster_id[i]};
                            hit = 1'b1;
                        end
                        seen++;
                    end
                end
                a.ok = hit;
            end
            default: begin
            end
        endcase
        a.member_count = roster_count[6:0];
        return a;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle)
            return 0;
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Id of some occupied slot, so removes and lookups hit.
    function automatic logic [ID_W-1:0] pick_present_id();
        int start;
        int idx;
        start = $urandom_range(0, SLOTS - 1);
        for (int k = 0; k < SLOTS; k++) begin
            idx = (start + k) % SLOTS;
            if (roster_used[idx])
                return roster_id[idx];
        end
        return ID_W'($urandom);
    endfunction

    // Mix of present ids, a small pool that makes duplicates, extremes and noise.
    function automatic logic [ID_W-1:0] pick_member_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40 && roster_count > 0)
            return pick_present_id();
        if (r < 55)
            return ID_W'($urandom_range(0, 7));
        if (r < 59)
            return '0;
        if (r < 63)
            return {ID_W{1'b1}};
        return ID_W'($urandom);
    endfunction

    // Send one request word and record its predicted answer once accepted.
    task automatic send_word(logic [FUNC_W-1:0] f, logic [ID_W-1:0] id,
                             logic [SR_W-1:0] sr);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.func         <= f;
        req_if.member_id    <= id;
        req_if.slot_or_rank <= sr;
        do
            @(posedge i_clk);
        while (req_if.ready !== 1'b1);
        answer_q.push_back(roster_apply(f, id, sr));
    endtask

    // Hold the request side idle until every predicted answer has come back.
    task automatic wait_all_answered();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (answer_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_desired_count(logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(4 * int'(mst_pkg::REG_DESIRED_COUNT));
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        roster_target = value[6:0];
    endtask

    task automatic check_desired_count();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= APB_AW'(4 * int'(mst_pkg::REG_DESIRED_COUNT));
        @(posedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (pready !== 1'b1);
        if (prdata[6:0] !== roster_target) begin
            $error("desired_count readback: expected %0d, actual %0d",
                   roster_target, prdata[6:0]);
            err_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Cumulative weights per mood over func codes 0..7: grow, shrink, balanced.
    int mood_weight [3][8] = '{
        '{55, 62, 68, 69, 73, 85, 98, 100},
        '{15, 40, 62, 65, 75, 85, 97, 100},
        '{30, 45, 58, 60, 68, 80, 97, 100}
    };

    task automatic send_random_word(int mood);
        int r;
        logic [FUNC_W-1:0] f;
        logic [SR_W-1:0] sr;
        r = $urandom_range(0, 99);
        f = F_UNUSED;
        for (int k = 7; k >= 0; k--)
            if (r < mood_weight[mood][k])
                f = FUNC_W'(k);
        r = $urandom_range(0, 99);
        if (f == mst_pkg::F_NTH && r < 85)
            sr = SR_W'($urandom_range(0,
                       (roster_count + 2 > 127) ? 127 : roster_count + 2));
        else if (f != mst_pkg::F_NTH && r < 80)
            sr = SR_W'($urandom_range(0, SLOTS - 1));
        else
            sr = SR_W'($urandom_range(0, 127));
        send_word(f, pick_member_id(), sr);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    task automatic test_config_readback();
        check_desired_count();
        write_desired_count(32'd127);
        check_desired_count();
        write_desired_count(32'd64);
        check_desired_count();
        write_desired_count(32'd0);
        check_desired_count();
    endtask

    // Every operation at least once, the id extremes, and the single-word corner cases.
    task automatic test_directed_ops();
        write_desired_count(32'd2);
        send_word(mst_pkg::F_INSERT, '0, '0);
        send_word(mst_pkg::F_INSERT, {ID_W{1'b1}}, '0);
        send_word(mst_pkg::F_INSERT, 31'd12345, '0);
        send_word(mst_pkg::F_INSERT, '0, '0);                // duplicate id in slot 3
        send_word(mst_pkg::F_CONTAINS, {ID_W{1'b1}}, '0);
        send_word(mst_pkg::F_CONTAINS, 31'd55, '0);          // id not present
        send_word(mst_pkg::F_NTH, '0, 7'd0);
        send_word(mst_pkg::F_NTH, '0, 7'd3);
        send_word(mst_pkg::F_NTH, '0, 7'd4);                 // rank too large
        send_word(mst_pkg::F_NTH, '0, 7'd127);
        send_word(mst_pkg::F_REMOVE_ID, '0, '0);             // first match only
        send_word(mst_pkg::F_REMOVE_ID, 31'd99, '0);         // id not present
        send_word(mst_pkg::F_REMOVE_SLOT, '0, 7'd0);         // slot already empty
        send_word(mst_pkg::F_REMOVE_SLOT, '0, 7'd1);
        send_word(mst_pkg::F_REMOVE_SLOT, '0, 7'd64);        // slot out of range
        send_word(mst_pkg::F_REMOVE_SLOT, '0, 7'd127);
        send_word(F_UNUSED, {ID_W{1'b1}}, 7'd127);
        send_word(mst_pkg::F_INSERT, 31'd5, '0);             // reuses lowest free slot
        send_word(mst_pkg::F_INSERT, 31'd6, '0);
        send_word(mst_pkg::F_TRIM, '0, '0);
        send_word(mst_pkg::F_TRIM, '0, '0);                  // nothing left to trim
        send_word(mst_pkg::F_CLEAR, '0, '0);
        send_word(mst_pkg::F_TRIM, '0, '0);                  // empty table
        send_word(mst_pkg::F_NTH, '0, 7'd0);
        wait_all_answered();
    endtask

    // Fill the table, overflow it, then trim from the top settings down.
    task automatic test_full_table();
        write_desired_count(32'd64);
        send_word(mst_pkg::F_CLEAR, '0, '0);
        for (int i = 0; i < SLOTS; i++)
            send_word(mst_pkg::F_INSERT, pick_member_id(), '0);
        send_word(mst_pkg::F_INSERT, 31'd77, '0);            // table full
        send_word(mst_pkg::F_TRIM, '0, '0);                  // target equals count
        send_word(mst_pkg::F_NTH, '0, 7'(SLOTS - 1));
        send_word(mst_pkg::F_NTH, '0, 7'(SLOTS));
        send_word(mst_pkg::F_REMOVE_SLOT, '0, 7'(SLOTS - 1));
        send_word(mst_pkg::F_INSERT, {ID_W{1'b1}}, '0);
        wait_all_answered();
        write_desired_count(32'd40);
        send_word(mst_pkg::F_TRIM, '0, '0);
        send_word(mst_pkg::F_NTH, '0, 7'd39);
        send_word(mst_pkg::F_NTH, '0, 7'd40);
        wait_all_answered();
        write_desired_count(32'd0);
        send_word(mst_pkg::F_TRIM, '0, '0);
        send_word(mst_pkg::F_CONTAINS, pick_member_id(), '0);
        wait_all_answered();
    endtask

    // Words back to back with the result side ready once any running stall ends.
    task automatic test_back_to_back();
        write_desired_count(32'd20);
        no_idle = 1'b1;
        for (int i = 0; i < 40; i++)
            send_random_word((i < 25) ? 0 : 2);
        wait_all_answered();
        no_idle = 1'b0;
    endtask

    // Random mix across several trim targets, mood picked anew every 20 words.
    task automatic test_random_mix();
        logic [31:0] targets [6];
        int mood;
        targets = '{32'd0, 32'd64, 32'd127, 32'd40, 32'($urandom_range(1, 63)),
                    32'($urandom_range(0, 127))};
        for (int p = 0; p < 6; p++) begin
            wait_all_answered();
            write_desired_count(targets[p]);
            mood = 2;
            for (int i = 0; i < 70; i++) begin
                if (i % 20 == 0)
                    mood = $urandom_range(0, 2);
                // Pause now and then until the block has answered everything.
                if ($urandom_range(0, 99) < 3)
                    wait_all_answered();
                send_random_word(mood);
            end
        end
        wait_all_answered();
    endtask

    // ---------------------------------------------------------------
    // Result side: random stalls, compare each word with the oldest answer
    // ---------------------------------------------------------------

    initial begin
        t_member_answer want;
        int hold;
        int r;
        hold = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
                if (answer_q.size() == 0) begin
                    $error("result word with no request pending: ok=%0b found_id=%0d count=%0d",
                           rsp_if.ok, rsp_if.found_id, rsp_if.member_count);
                    err_count++;
                end else begin
                    want = answer_q.pop_front();
                    if (rsp_if.ok !== want.ok) begin
                        $error("ok: expected %0b, actual %0b", want.ok, rsp_if.ok);
                        err_count++;
                    end
                    if (rsp_if.found_id !== want.found_id) begin
                        $error("found_id: expected %0d, actual %0d",
                               $signed(want.found_id), rsp_if.found_id);
                        err_count++;
                    end
                    if (rsp_if.member_count !== want.member_count) begin
                        $error("member_count: expected %0d, actual %0d",
                               want.member_count, rsp_if.member_count);
                        err_count++;
                    end
                end
            end
            // Drive ready in stretches: mostly open, short stalls, a few long.
            if (hold > 0) begin
                hold--;
            end else if (no_idle) begin
                rsp_if.ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    rsp_if.ready <= 1'b1;
                    hold = $urandom_range(0, 8);
                end else if (r < 95) begin
                    rsp_if.ready <= 1'b0;
                    hold = $urandom_range(0, 2);
                end else begin
                    rsp_if.ready <= 1'b0;
                    hold = $urandom_range(15, 50);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------

    initial begin
        err_count   = 0;
        cycle_count = 0;
        no_idle     = 1'b0;
        roster_empty();
        roster_target = '0;
        // Drive every input to a known value before the first edge.
        i_rst_n             <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        req_if.valid        <= 1'b0;
        req_if.func         <= mst_pkg::F_INSERT;
        req_if.member_id    <= '0;
        req_if.slot_or_rank <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_config_readback();
        test_directed_ops();
        test_full_table();
        test_back_to_back();
        test_random_mix();

        // Let any stray word show up before the verdict.
        wait_all_answered();
        repeat (SLOTS + 8) @(posedge i_clk);
        if (answer_q.size() != 0) begin
            $error("%0d answers still outstanding at end of run", answer_q.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/mst_pkg.sv
rtl/mst_if.sv
rtl/mst_ram.sv
rtl/mst_apb.sv
rtl/mst_engine.sv
rtl/member_slot_table_core.sv
tb/sv/tb_member_slot_table_core.sv
